// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TGA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define TGA_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TGA_ASSERT(lbl, clk, rstn, prop)
`define TGA_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== sv/tga_pkg.sv =====
// ---------------------------------------------------------------------------
// tga_pkg
// Types and constants of the Targa RLE pixel encoder.
// ---------------------------------------------------------------------------
package tga_pkg;

  localparam int MAX_PACKET_DEF = 128;
  localparam int PIX_W          = 24;
  localparam int CH_W           = 8;
  localparam int HDR_W          = 8;
  localparam int HDR_CNT_W      = 7;
  localparam int PCNT_W         = 3;
  localparam int LANES          = 4;
  localparam int LANE_W         = 2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last_pixel;
  } in_req_t;

  typedef struct packed {
    logic              has_header;
    logic [HDR_W-1:0]  packet_header;
    logic [PCNT_W-1:0] pixel_count;
    logic [PIX_W-1:0]  pixel_a;
    logic [PIX_W-1:0]  pixel_b;
    logic [PIX_W-1:0]  pixel_c;
    logic [PIX_W-1:0]  pixel_d;
    logic              last_of_run;
    logic              image_done;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_TAIL1,
    ST_TAIL2
  } state_e;

endpackage

// ===== sv/tga_rle_pixel_encoder.sv =====
// ---------------------------------------------------------------------------
// tga_rle_pixel_encoder
// Targa run-length packet encoder for 24-bit pixels.
// ---------------------------------------------------------------------------
// Pixels enter one per request in scan order; results leave as packets with
// an optional header byte and up to four B,G,R pixel words each. An item
// that closes no packet leaves the sequencer idle. A raw packet of N pixels
// is read out of four 24-bit bank RAMs (one row of four pixels per result):
// each row is read in ST_READ and loaded in ST_WAIT once the output register
// is free; a run packet or a single-pixel raw packet is sent from ST_TAIL1 or
// ST_TAIL2. The block store needs no clearing pass after reset; a new request
// is taken only when the packet sequencer is idle, while the last result may
// still wait in the output register.
`include "assert_macros.svh"

module tga_rle_pixel_encoder
  import tga_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_res_t out_res_o
);

  localparam int CNT_RAW   = $clog2(MAX_PACKET + 1);
  localparam int CNT_W     = (CNT_RAW < 3) ? 3 : CNT_RAW;
  localparam int ROWS      = (MAX_PACKET + LANES - 1) / LANES;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RAM_DEPTH = 2 ** ROW_W;

  localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_PACKET);
  localparam logic [CNT_W-1:0] LANES_C = CNT_W'(LANES);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

  state_e state_q, state_d;

  logic [CNT_W-1:0] len_q, len_d;
  logic             run_q, run_d;
  logic [PIX_W-1:0] prev_q;
  logic [CNT_W-1:0] rem_q;
  logic [ROW_W-1:0] row_q;
  logic             first_q;
  logic [HDR_W-1:0] hdr_raw_q;
  logic             t1_v_q, t2_v_q, last_q;
  logic [HDR_W-1:0] t1_hdr_q;
  logic [PIX_W-1:0] t1_px_q;
  logic             out_valid_q;
  out_res_t         out_q, out_d;

  logic             in_fire, load_ok, load_en, rd_en;
  logic [PIX_W-1:0] px;
  logic             same;
  logic [CNT_W-1:0] len_inc, raw_n, wr_idx;
  logic             wr_en, t1_v, t2_v;
  logic [HDR_W-1:0] t1_hdr;
  logic [PCNT_W-1:0] row_cnt;
  logic             rows_more;
  logic [PIX_W-1:0] rd_data [LANES];
  logic [PIX_W-1:0] row_px  [LANES];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_ok     = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  assign px      = {in_req_i.red, in_req_i.green, in_req_i.blue};
  assign same    = (px == prev_q);
  assign len_inc = len_q + ONE_C;

  // step decision
  always_comb begin
    raw_n  = '0;
    wr_en  = 1'b0;
    wr_idx = '0;
    t1_v   = 1'b0;
    t1_hdr = '0;
    t2_v   = 1'b0;
    len_d  = len_q;
    run_d  = run_q;
    if (len_q == '0) begin
      wr_en = 1'b1;
      len_d = ONE_C;
      run_d = 1'b0;
      if (in_req_i.last_pixel) begin
        t2_v  = 1'b1;
        len_d = '0;
      end
    end else if (!run_q) begin
      if (!same) begin
        wr_en  = 1'b1;
        wr_idx = len_q;
        len_d  = len_inc;
        if (len_inc == MAX_C || in_req_i.last_pixel) begin
          raw_n = len_inc;
          len_d = '0;
        end
      end else begin
        if (len_q > ONE_C) begin
          raw_n = len_q - ONE_C;
        end
        len_d = TWO_C;
        run_d = 1'b1;
        if (MAX_C == TWO_C || in_req_i.last_pixel) begin
          t1_v   = 1'b1;
          t1_hdr = {1'b1, HDR_CNT_W'(TWO_C - ONE_C)};
          len_d  = '0;
          run_d  = 1'b0;
        end
      end
    end else begin
      if (same) begin
        len_d = len_inc;
        if (len_inc == MAX_C || in_req_i.last_pixel) begin
          t1_v   = 1'b1;
          t1_hdr = {1'b1, HDR_CNT_W'(len_q)};
          len_d  = '0;
          run_d  = 1'b0;
        end
      end else begin
        t1_v   = 1'b1;
        t1_hdr = {1'b1, HDR_CNT_W'(len_q - ONE_C)};
        wr_en  = 1'b1;
        len_d  = ONE_C;
        run_d  = 1'b0;
        if (in_req_i.last_pixel) begin
          t2_v  = 1'b1;
          len_d = '0;
        end
      end
    end
  end

  // block store: pixel i lives in bank i[1:0], row i>>2
  for (genvar j = 0; j < LANES; j++) begin : g_bank
    tga_ram #(
      .WIDTH(PIX_W),
      .DEPTH(RAM_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (in_fire && wr_en && (wr_idx[LANE_W-1:0] == LANE_W'(j))),
      .waddr_i(ROW_W'(wr_idx >> LANE_W)),
      .wdata_i(px),
      .re_i   (rd_en),
      .raddr_i(row_q),
      .rdata_o(rd_data[j])
    );
    assign row_px[j] = (PCNT_W'(j) < row_cnt) ? rd_data[j] : '0;
  end

  assign row_cnt   = (rem_q >= LANES_C) ? PCNT_W'(LANES) : PCNT_W'(rem_q);
  assign rows_more = (rem_q > LANES_C);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (raw_n != '0) begin
            state_d = ST_READ;
          end else if (t1_v) begin
            state_d = ST_TAIL1;
          end else if (t2_v) begin
            state_d = ST_TAIL2;
          end
        end
      end
      ST_READ: state_d = ST_WAIT;
      ST_WAIT: begin
        if (load_ok) begin
          if (rows_more) begin
            state_d = ST_READ;
          end else if (t1_v_q) begin
            state_d = ST_TAIL1;
          end else if (t2_v_q) begin
            state_d = ST_TAIL2;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TAIL1: begin
        if (load_ok) begin
          state_d = t2_v_q ? ST_TAIL2 : ST_IDLE;
        end
      end
      ST_TAIL2: begin
        if (load_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en   = 1'b0;
    load_en = 1'b0;
    out_d   = '0;
    case (state_q)
      ST_READ: rd_en = 1'b1;
      ST_WAIT: begin
        load_en             = load_ok;
        out_d.has_header    = first_q;
        out_d.packet_header = first_q ? hdr_raw_q : '0;
        out_d.pixel_count   = row_cnt;
        out_d.pixel_a       = row_px[0];
        out_d.pixel_b       = row_px[1];
        out_d.pixel_c       = row_px[2];
        out_d.pixel_d       = row_px[3];
        out_d.last_of_run   = !rows_more && !t1_v_q && !t2_v_q;
        out_d.image_done    = out_d.last_of_run && last_q;
      end
      ST_TAIL1: begin
        load_en             = load_ok;
        out_d.has_header    = 1'b1;
        out_d.packet_header = t1_hdr_q;
        out_d.pixel_count   = PCNT_W'(1);
        out_d.pixel_a       = t1_px_q;
        out_d.last_of_run   = !t2_v_q;
        out_d.image_done    = !t2_v_q && last_q;
      end
      ST_TAIL2: begin
        load_en             = load_ok;
        out_d.has_header    = 1'b1;
        out_d.pixel_count   = PCNT_W'(1);
        out_d.pixel_a       = prev_q;
        out_d.last_of_run   = 1'b1;
        out_d.image_done    = last_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      t1_v_q      <= 1'b0;
      t2_v_q      <= 1'b0;
      rem_q       <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        len_q  <= len_d;
        run_q  <= run_d;
        t1_v_q <= t1_v;
        t2_v_q <= t2_v;
        rem_q  <= raw_n;
      end else if (state_q == ST_WAIT && load_ok) begin
        rem_q <= rem_q - CNT_W'(row_cnt);
      end
      if (load_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_q    <= px;
      t1_px_q   <= prev_q;
      t1_hdr_q  <= t1_hdr;
      hdr_raw_q <= HDR_W'(raw_n - ONE_C);
      last_q    <= in_req_i.last_pixel;
      row_q     <= '0;
      first_q   <= 1'b1;
    end else if (state_q == ST_WAIT && load_ok) begin
      row_q   <= row_q + ROW_W'(1);
      first_q <= 1'b0;
    end
    if (load_en) begin
      out_q <= out_d;
    end
  end

  `TGA_ASSERT(a_len_below_max, clk_i, rst_ni, len_q < MAX_C)
  `TGA_ASSERT(a_run_len_min, clk_i, rst_ni, run_q |-> (len_q >= TWO_C))
  `TGA_ASSERT(a_rows_pending, clk_i, rst_ni, (state_q == ST_READ || state_q == ST_WAIT) |-> (rem_q != '0))
  `TGA_NEVER(a_bad_count, clk_i, rst_ni, out_valid_q && (out_q.pixel_count == '0 || out_q.pixel_count > PCNT_W'(LANES)))

endmodule

// ===== sv/tga_ram.sv =====
// ---------------------------------------------------------------------------
// tga_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tga_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tga_rle_pixel_encoder_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tga_rle_pixel_encoder_tb
// Checks the Targa RLE pixel encoder against a cycle-free packet predictor.
// Pixels are fed from a queue by a falling-edge driver; every request taken
// updates the predictor, which queues the expected packet results. Results
// are compared field by field at the rising edge. Stimulus covers directed
// raw/run/flush cases, full-length blocks, random segments, random idling
// on both sides, a long output hold-off and drained pauses.
// ---------------------------------------------------------------------------
module tga_rle_pixel_encoder_tb;
  import tga_pkg::*;

  localparam int MAXP           = MAX_PACKET_DEF;
  localparam int RUN_BIT        = 128;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int N_DIRECTED     = 22;

  localparam logic [24:0] DIRECTED [N_DIRECTED] = '{
    {24'h000000, 1'b1},
    {24'hFF0000, 1'b0}, {24'h00FF00, 1'b0}, {24'h0000FF, 1'b0},
    {24'h0000FF, 1'b0}, {24'h0000FF, 1'b0}, {24'hFFFFFF, 1'b0},
    {24'hFFFFFF, 1'b0}, {24'hFFFFFF, 1'b0}, {24'h123456, 1'b1},
    {24'h010203, 1'b0}, {24'h040506, 1'b0}, {24'h070809, 1'b0},
    {24'h0A0B0C, 1'b0}, {24'h0D0E0F, 1'b0}, {24'h101112, 1'b0},
    {24'h101112, 1'b0}, {24'h202122, 1'b1},
    {24'hAAAAAA, 1'b0}, {24'h555555, 1'b1},
    {24'hFEFEFE, 1'b0}, {24'hFEFEFE, 1'b1}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_ready_i;
  out_res_t out_res_o;

  tga_rle_pixel_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  in_req_t     pixel_q[$];
  out_res_t    bgr_packet_q[$];
  logic [23:0] blk_store [MAXP];
  int          blk_len;
  bit          in_run;
  logic [23:0] prev_px;
  logic [23:0] palette [3];

  int err_count;
  int stall_cycles;
  int send_gap;
  int rx_gap;
  bit no_idle;
  bit hold_go;
  bit rx_hold;
  bit req_taken;
  bit res_taken;

  // predictor
  function automatic void emit_packet(logic [7:0] hdr, int n);
    out_res_t    r;
    logic [23:0] lane [4];
    int          cnt;
    for (int i = 0; i < n; i += 4) begin
      cnt = (n - i < 4) ? n - i : 4;
      for (int j = 0; j < 4; j++) begin
        lane[j] = (j < cnt) ? blk_store[i+j] : '0;
      end
      r               = '0;
      r.has_header    = (i == 0);
      r.packet_header = (i == 0) ? hdr : '0;
      r.pixel_count   = PCNT_W'(cnt);
      r.pixel_a       = lane[0];
      r.pixel_b       = lane[1];
      r.pixel_c       = lane[2];
      r.pixel_d       = lane[3];
      bgr_packet_q.push_back(r);
    end
  endfunction

  function automatic void flush_block();
    if (blk_len == 0) return;
    if (in_run) emit_packet(8'(RUN_BIT + blk_len - 1), 1);
    else emit_packet(8'(blk_len - 1), blk_len);
    blk_len = 0;
    in_run  = 1'b0;
  endfunction

  function automatic void encode_pixel(in_req_t req);
    logic [23:0] px;
    int          n_prior;
    out_res_t    r;
    px      = {req.red, req.green, req.blue};
    n_prior = bgr_packet_q.size();
    if (blk_len == 0) begin
      blk_store[0] = px;
      blk_len      = 1;
      in_run       = 1'b0;
    end else if (!in_run) begin
      if (blk_store[blk_len-1] != px) begin
        if (blk_len < MAXP) begin
          blk_store[blk_len] = px;
          blk_len++;
        end
      end else begin
        if (blk_len > 1) emit_packet(8'(blk_len - 2), blk_len - 1);
        blk_store[0] = px;
        blk_len      = 2;
        in_run       = 1'b1;
      end
    end else begin
      if (blk_store[0] == px) begin
        if (blk_len < MAXP) blk_len++;
      end else begin
        emit_packet(8'(RUN_BIT + blk_len - 1), 1);
        blk_store[0] = px;
        blk_len      = 1;
        in_run       = 1'b0;
      end
    end
    if (blk_len >= MAXP) flush_block();
    if (req.last_pixel) flush_block();
    if (bgr_packet_q.size() > n_prior) begin
      r             = bgr_packet_q.pop_back();
      r.last_of_run = 1'b1;
      r.image_done  = req.last_pixel;
      bgr_packet_q.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // stimulus helpers
  function automatic void queue_pixel(logic [23:0] px, bit last);
    in_req_t req;
    req.red        = px[23:16];
    req.green      = px[15:8];
    req.blue       = px[7:0];
    req.last_pixel = last;
    pixel_q.push_back(req);
    prev_px = px;
  endfunction

  function automatic logic [23:0] other_pixel();
    logic [23:0] p;
    p = 24'($urandom());
    if (p == prev_px) p = ~p;
    return p;
  endfunction

  function automatic void queue_block(int n, bit same);
    logic [23:0] px;
    px = other_pixel();
    for (int k = 0; k < n; k++) begin
      queue_pixel(px, 1'b0);
      if (!same) px = other_pixel();
    end
  endfunction

  function automatic void gen_traffic(int n_items);
    int      added;
    int      len;
    int      kind;
    in_req_t req;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 10);
      if (kind < 4) begin
        queue_block(len, 1'b0);
      end else if (kind < 7) begin
        len = $urandom_range(2, 10);
        queue_block(len, 1'b1);
      end else begin
        for (int k = 0; k < len; k++) begin
          queue_pixel(palette[$urandom_range(0, 2)], $urandom_range(0, 5) == 0);
        end
      end
      if (kind < 7 && $urandom_range(0, 4) == 0) begin
        req            = pixel_q.pop_back();
        req.last_pixel = 1'b1;
        pixel_q.push_back(req);
      end
      added += len;
    end
  endfunction

  task automatic wait_drained();
    while (pixel_q.size() > 0 || in_valid_i || bgr_packet_q.size() > 0) @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !req_taken)) begin
      if (in_valid_i) send_gap = no_idle ? 0 : $urandom_range(0, 6);
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_req_i   <= pixel_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) rx_gap = no_idle ? 0 : $urandom_range(0, 6);
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    out_res_t want;
    req_taken <= in_valid_i && in_ready_o;
    res_taken <= out_valid_o && out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) encode_pixel(in_req_i);
      if (out_valid_o && out_ready_i) begin
        if (bgr_packet_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_res_o));
        end else begin
          want = bgr_packet_q.pop_front();
          check_field("has_header", 32'(out_res_o.has_header), 32'(want.has_header));
          check_field("packet_header", 32'(out_res_o.packet_header),
                      32'(want.packet_header));
          check_field("pixel_count", 32'(out_res_o.pixel_count), 32'(want.pixel_count));
          check_field("pixel_a", 32'(out_res_o.pixel_a), 32'(want.pixel_a));
          check_field("pixel_b", 32'(out_res_o.pixel_b), 32'(want.pixel_b));
          check_field("pixel_c", 32'(out_res_o.pixel_c), 32'(want.pixel_c));
          check_field("pixel_d", 32'(out_res_o.pixel_d), 32'(want.pixel_d));
          check_field("last_of_run", 32'(out_res_o.last_of_run), 32'(want.last_of_run));
          check_field("image_done", 32'(out_res_o.image_done), 32'(want.image_done));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_ready_i  = 1'b0;
    err_count    = 0;
    stall_cycles = 0;
    send_gap     = 0;
    rx_gap       = 0;
    no_idle      = 1'b0;
    hold_go      = 1'b0;
    req_taken    = 1'b0;
    res_taken    = 1'b0;
    blk_len      = 0;
    in_run       = 1'b0;
    prev_px      = '0;
    for (int k = 0; k < 3; k++) palette[k] = 24'($urandom());
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) pixel_q.push_back(in_req_t'(DIRECTED[k]));
    wait_drained();

    // full raw and full run blocks; output held off to back up the input
    queue_block(MAXP, 1'b0);
    queue_block(MAXP, 1'b1);
    while (bgr_packet_q.size() == 0) @(posedge clk_i);
    hold_go = 1'b1;
    wait_drained();

    no_idle = 1'b1;
    gen_traffic(10);
    wait_drained();

    no_idle = 1'b0;
    gen_traffic(10);
    wait_drained();

    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
